/* hdl/bmhpq_pkg.sv */
`default_nettype none

package bmhpq_pkg;

  // Fixed field widths of the channels
  localparam int ACT_W  = 3;
  localparam int DATA_W = 32;
  localparam int POS_W  = 6;
  localparam int CNT_W  = 7;
  localparam int STAT_W = 2;

  // Default sizing
  localparam int DEF_CAPACITY    = 64;
  localparam int DEF_VALUE_WIDTH = 32;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_INSERT = 3'd0;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 3'd1;
  localparam logic [ACT_W-1:0] ACT_CHANGE = 3'd2;
  localparam logic [ACT_W-1:0] ACT_READ   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd4;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;
  localparam logic [STAT_W-1:0] ST_BADIDX = 2'd3;

endpackage

`default_nettype wire

/* hdl/binary_max_heap_priority_queue.sv */
// Channel | Direction | Handshake         | Payload
// in_     | input     | in_valid/in_stall | in_action, in_item_value, in_position
// out_    | output    | out_valid/out_stall | out_result_value, out_top_value,
//         |           |                   |   out_entry_count, out_status
//
// One item at a time. Errors, clear, unused actions and a remove of the last entry
// go straight to the result state; read and change to an equal value read the entry at
// the index; insert sifts up, remove sifts down and change sifts either way, level by
// level, each level waiting on the registered heap read.
// Reset (rst_n, synchronous) empties the queue; heap memory is not cleared.
// in_stall is high while an item is in progress; a finished result waits in
// the output register while out_stall is high, and the next item may enter.
`default_nettype none

module binary_max_heap_priority_queue #(
  parameter int CAPACITY    = bmhpq_pkg::DEF_CAPACITY,
  parameter int VALUE_WIDTH = bmhpq_pkg::DEF_VALUE_WIDTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [bmhpq_pkg::ACT_W-1:0]   in_action,
  input  wire logic [bmhpq_pkg::DATA_W-1:0]  in_item_value,
  input  wire logic [bmhpq_pkg::POS_W-1:0]   in_position,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [bmhpq_pkg::DATA_W-1:0]       out_result_value,
  output logic [bmhpq_pkg::DATA_W-1:0]       out_top_value,
  output logic [bmhpq_pkg::CNT_W-1:0]        out_entry_count,
  output logic [bmhpq_pkg::STAT_W-1:0]       out_status
);
  import bmhpq_pkg::*;

  // Stored width, index width, count width, position-compare width, child-index width
  localparam int SW  = (VALUE_WIDTH < DATA_W) ? VALUE_WIDTH : DATA_W;
  localparam int IW  = $clog2(CAPACITY);
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int PCW = (CW > POS_W) ? CW : POS_W;
  localparam int LW  = IW + 2;

  typedef enum logic [3:0] {
    S_IDLE, S_UP_RD, S_UP_CMP, S_LAST_RD, S_LAST_LD,
    S_DN_RD, S_DN_CMP, S_IDX_RD, S_IDX_CMP, S_FIN
  } state_t;

  state_t              state_r, state_nxt;
  logic [ACT_W-1:0]    act_r, act_nxt;
  logic [SW-1:0]       val_r, val_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [IW-1:0]       hole_r, hole_nxt;
  logic [SW-1:0]       cur_r, cur_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [SW-1:0]       top_r;
  logic [SW-1:0]       res_r, res_nxt;
  logic [STAT_W-1:0]   st_r, st_nxt;
  logic                out_valid_r;
  logic [DATA_W-1:0]   out_result_value_r, out_top_value_r;
  logic [CNT_W-1:0]    out_entry_count_r;
  logic [STAT_W-1:0]   out_status_r;

  // Heap memory: one write port, two registered read ports
  logic [SW-1:0]       heap_mem [CAPACITY];
  logic                we_c;
  logic [IW-1:0]       wa_c, ra_a_c, ra_b_c;
  logic [SW-1:0]       wd_c, rd_a_r, rd_b_r;

  // Tree navigation around the hole
  logic [IW-1:0]       parent_c;
  logic [LW-1:0]       left_c, right_c, n_c;
  logic                out_free_c;

  assign parent_c   = (hole_r - IW'(1)) >> 1;
  assign left_c     = {1'b0, hole_r, 1'b1};
  assign right_c    = left_c + LW'(1);
  assign n_c        = LW'(count_r);
  assign out_free_c = !out_valid_r || !out_stall;

  // Sequencer next-state and memory port control
  always_comb begin
    state_nxt = state_r;
    act_nxt   = act_r;
    val_nxt   = val_r;
    pos_nxt   = pos_r;
    hole_nxt  = hole_r;
    cur_nxt   = cur_r;
    count_nxt = count_r;
    res_nxt   = res_r;
    st_nxt    = st_r;
    we_c      = 1'b0;
    wa_c      = hole_r;
    wd_c      = cur_r;
    ra_a_c    = hole_r;
    ra_b_c    = hole_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          act_nxt   = in_action;
          val_nxt   = in_item_value[SW-1:0];
          pos_nxt   = in_position;
          res_nxt   = '0;
          st_nxt    = ST_OK;
          state_nxt = S_FIN;
          case (in_action)
            ACT_INSERT: begin
              if (count_r == CW'(CAPACITY)) begin
                st_nxt = ST_FULL;
              end else begin
                hole_nxt  = IW'(count_r);
                cur_nxt   = in_item_value[SW-1:0];
                count_nxt = count_r + CW'(1);
                state_nxt = S_UP_RD;
              end
            end
            ACT_REMOVE: begin
              if (count_r == '0) begin
                st_nxt = ST_EMPTY;
              end else begin
                res_nxt   = top_r;
                count_nxt = count_r - CW'(1);
                if (count_r != CW'(1)) state_nxt = S_LAST_RD;
              end
            end
            ACT_CHANGE, ACT_READ: begin
              if (PCW'(in_position) >= PCW'(count_r)) st_nxt = ST_BADIDX;
              else state_nxt = S_IDX_RD;
            end
            ACT_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      // Sift up: read parent of the hole
      S_UP_RD: begin
        if (hole_r == '0) begin
          we_c      = 1'b1;
          state_nxt = S_FIN;
        end else begin
          ra_a_c    = parent_c;
          state_nxt = S_UP_CMP;
        end
      end
      // Sift up: parent moves down into the hole if strictly smaller
      S_UP_CMP: begin
        we_c = 1'b1;
        if (cur_r > rd_a_r) begin
          wd_c      = rd_a_r;
          hole_nxt  = parent_c;
          state_nxt = S_UP_RD;
        end else begin
          state_nxt = S_FIN;
        end
      end
      // Remove: fetch the last entry, it sifts down from the root
      S_LAST_RD: begin
        ra_a_c    = IW'(count_r);
        state_nxt = S_LAST_LD;
      end
      S_LAST_LD: begin
        cur_nxt   = rd_a_r;
        hole_nxt  = '0;
        state_nxt = S_DN_RD;
      end
      // Sift down: read both children of the hole
      S_DN_RD: begin
        if (left_c >= n_c) begin
          we_c      = 1'b1;
          state_nxt = S_FIN;
        end else begin
          ra_a_c    = IW'(left_c);
          ra_b_c    = IW'(right_c);
          state_nxt = S_DN_CMP;
        end
      end
      // Sift down: larger child moves up; left wins a tie
      S_DN_CMP: begin
        we_c = 1'b1;
        if (right_c < n_c && rd_b_r > cur_r && rd_b_r > rd_a_r) begin
          wd_c      = rd_b_r;
          hole_nxt  = IW'(right_c);
          state_nxt = S_DN_RD;
        end else if (rd_a_r > cur_r) begin
          wd_c      = rd_a_r;
          hole_nxt  = IW'(left_c);
          state_nxt = S_DN_RD;
        end else begin
          state_nxt = S_FIN;
        end
      end
      // Read or change: fetch the entry at the index
      S_IDX_RD: begin
        ra_a_c    = IW'(pos_r);
        state_nxt = S_IDX_CMP;
      end
      S_IDX_CMP: begin
        state_nxt = S_FIN;
        if (act_r == ACT_READ) begin
          res_nxt = rd_a_r;
        end else if (val_r != rd_a_r) begin
          hole_nxt  = IW'(pos_r);
          cur_nxt   = val_r;
          state_nxt = (val_r < rd_a_r) ? S_DN_RD : S_UP_RD;
        end
      end
      S_FIN: begin
        if (out_free_c) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Heap memory
  always_ff @(posedge clk) begin
    if (we_c) heap_mem[wa_c] <= wd_c;
    rd_a_r <= heap_mem[ra_a_c];
    rd_b_r <= heap_mem[ra_b_c];
  end

  // State, working registers, root copy and output register
  always_ff @(posedge clk) begin
    act_r  <= act_nxt;
    val_r  <= val_nxt;
    pos_r  <= pos_nxt;
    hole_r <= hole_nxt;
    cur_r  <= cur_nxt;
    res_r  <= res_nxt;
    st_r   <= st_nxt;
    if (we_c && wa_c == '0) top_r <= wd_c;
    if (state_r == S_FIN && out_free_c) begin
      out_result_value_r <= DATA_W'(res_r);
      out_top_value_r    <= (count_r != '0) ? DATA_W'(top_r) : '0;
      out_entry_count_r  <= CNT_W'(count_r);
      out_status_r       <= st_r;
    end
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (state_r == S_FIN && out_free_c) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_result_value = out_result_value_r;
  assign out_top_value    = out_top_value_r;
  assign out_entry_count  = out_entry_count_r;
  assign out_status       = out_status_r;

endmodule

`default_nettype wire

/* hdl/bmhpq_checker.sv */
`default_nettype none

module bmhpq_checker #(
  parameter int CAPACITY = bmhpq_pkg::DEF_CAPACITY
) (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_stall,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic [bmhpq_pkg::DATA_W-1:0]  out_result_value,
  input wire logic [bmhpq_pkg::DATA_W-1:0]  out_top_value,
  input wire logic [bmhpq_pkg::CNT_W-1:0]   out_entry_count,
  input wire logic [bmhpq_pkg::STAT_W-1:0]  out_status
);
  import bmhpq_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result_value)
      && $stable(out_top_value) && $stable(out_entry_count) && $stable(out_status))
    else $error("stalled result changed");

  // An accepted item keeps the block busy in the next cycle
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("not busy after accepting an item");

  // Empty status only on an empty queue
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_EMPTY |->
      out_entry_count == '0 && out_top_value == '0 && out_result_value == '0)
    else $error("empty status with stored entries");

  // Full status reports a full queue
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |->
      out_entry_count == CNT_W'(CAPACITY) && out_result_value == '0)
    else $error("full status with a wrong count");

  // Bad index returns no value
  a_badidx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_BADIDX |-> out_result_value == '0)
    else $error("bad index with a value");

endmodule

bind binary_max_heap_priority_queue bmhpq_checker #(.CAPACITY(CAPACITY)) u_bmhpq_checker (.*);

`default_nettype wire

/* tb/sv/pq_check_pkg.sv */
`timescale 1ns / 1ps

package pq_check_pkg;
  import bmhpq_pkg::*;

  localparam int HEAP_DEPTH = DEF_CAPACITY;

  // One result item of the queue
  typedef struct packed {
    logic [DATA_W-1:0] result_value;
    logic [DATA_W-1:0] top_value;
    logic [CNT_W-1:0]  entry_count;
    logic [STAT_W-1:0] status;
  } heap_reply_t;

  class pq_scoreboard;
    logic [DATA_W-1:0] heap_mem [HEAP_DEPTH];
    int unsigned       fill;
    heap_reply_t       expected_replies[$];
    int unsigned       mismatches;

    function new();
      fill       = 0;
      mismatches = 0;
    endfunction

    function void swap_slots(int unsigned a, int unsigned b);
      logic [DATA_W-1:0] t;
      t           = heap_mem[a];
      heap_mem[a] = heap_mem[b];
      heap_mem[b] = t;
    endfunction

    // move toward the root while strictly greater than the parent
    function void bubble_up(int unsigned idx);
      int unsigned parent;
      while (idx > 0) begin
        parent = (idx - 1) / 2;
        if (heap_mem[idx] > heap_mem[parent]) begin
          swap_slots(idx, parent);
          idx = parent;
        end else begin
          break;
        end
      end
    endfunction

    // move toward the leaves; left child wins a tie
    function void push_down(int unsigned idx);
      int unsigned big;
      int unsigned lc;
      int unsigned rc;
      while (idx < fill) begin
        big = idx;
        lc  = 2 * idx + 1;
        rc  = lc + 1;
        if (lc < fill && heap_mem[lc] > heap_mem[big]) big = lc;
        if (rc < fill && heap_mem[rc] > heap_mem[big]) big = rc;
        if (big == idx) break;
        swap_slots(idx, big);
        idx = big;
      end
    endfunction

    // apply one accepted item and queue the result it must produce
    function void note_request(logic [ACT_W-1:0] action, logic [DATA_W-1:0] value,
                               logic [POS_W-1:0] pos);
      heap_reply_t       rep;
      logic [DATA_W-1:0] old_value;
      rep        = '0;
      rep.status = ST_OK;
      case (action)
        ACT_INSERT: begin
          if (fill >= HEAP_DEPTH) begin
            rep.status = ST_FULL;
          end else begin
            heap_mem[fill] = value;
            bubble_up(fill);
            fill++;
          end
        end
        ACT_REMOVE: begin
          if (fill == 0) begin
            rep.status = ST_EMPTY;
          end else begin
            rep.result_value = heap_mem[0];
            fill--;
            heap_mem[0] = heap_mem[fill];
            push_down(0);
          end
        end
        ACT_CHANGE: begin
          if (pos >= fill) begin
            rep.status = ST_BADIDX;
          end else if (value != heap_mem[pos]) begin
            old_value     = heap_mem[pos];
            heap_mem[pos] = value;
            if (value < old_value) push_down(pos);
            else bubble_up(pos);
          end
        end
        ACT_READ: begin
          if (pos >= fill) rep.status = ST_BADIDX;
          else rep.result_value = heap_mem[pos];
        end
        ACT_CLEAR: begin
          fill = 0;
        end
        default: ;
      endcase
      rep.top_value   = (fill > 0) ? heap_mem[0] : '0;
      rep.entry_count = CNT_W'(fill);
      expected_replies.push_back(rep);
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      $display("%0t ns  mismatch: %s", $time, msg);
    endtask

    // compare one accepted result against the oldest expectation
    task check_reply(logic [DATA_W-1:0] res, logic [DATA_W-1:0] top,
                     logic [CNT_W-1:0] cnt, logic [STAT_W-1:0] st);
      heap_reply_t want;
      if (expected_replies.size() == 0) begin
        report_mismatch($sformatf("result with no item outstanding (value %h)", res));
        return;
      end
      want = expected_replies.pop_front();
      if (res !== want.result_value)
        report_mismatch($sformatf("result_value %h, want %h", res, want.result_value));
      if (top !== want.top_value)
        report_mismatch($sformatf("top_value %h, want %h", top, want.top_value));
      if (cnt !== want.entry_count)
        report_mismatch($sformatf("entry_count %0d, want %0d", cnt, want.entry_count));
      if (st !== want.status)
        report_mismatch($sformatf("status %0d, want %0d", st, want.status));
    endtask

    function int pending();
      return expected_replies.size();
    endfunction
  endclass

endpackage

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb;
  import bmhpq_pkg::*;
  import pq_check_pkg::*;

  localparam logic [ACT_W-1:0] ACT_UNUSED_LO = 3'd5;
  localparam logic [ACT_W-1:0] ACT_UNUSED_HI = 3'd7;
  localparam int RANDOM_ITEMS = 1330;
  localparam int QUIET_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 40;

  logic              clk           = 1'b0;
  logic              rst_n         = 1'b0;
  logic              in_valid      = 1'b0;
  logic [ACT_W-1:0]  in_action     = '0;
  logic [DATA_W-1:0] in_item_value = '0;
  logic [POS_W-1:0]  in_position   = '0;
  logic              out_stall     = 1'b0;
  logic              in_stall;
  logic              out_valid;
  logic [DATA_W-1:0] out_result_value;
  logic [DATA_W-1:0] out_top_value;
  logic [CNT_W-1:0]  out_entry_count;
  logic [STAT_W-1:0] out_status;

  pq_scoreboard sb = new();

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_req       = 1'b0;
  int level          = 0;
  int items_sent     = 0;

  binary_max_heap_priority_queue u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_item_value    (in_item_value),
    .in_position      (in_position),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_value (out_result_value),
    .out_top_value    (out_top_value),
    .out_entry_count  (out_entry_count),
    .out_status       (out_status)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // handshake monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_request(in_action, in_item_value, in_position);
      if (out_valid && !out_stall)
        sb.check_reply(out_result_value, out_top_value, out_entry_count, out_status);
    end
  end

  // watchdog on cycles with no handshake at all
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("FAILURE");
    $finish;
  end

  // offer one item and hold it until accepted
  task send_item(input logic [ACT_W-1:0] act, input logic [DATA_W-1:0] value,
                 input logic [POS_W-1:0] pos);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_action     <= act;
    in_item_value <= value;
    in_position   <= pos;
    do @(posedge clk); while (in_stall);
    items_sent++;
    // rough fill level, only to shape the stimulus
    case (act)
      ACT_INSERT: if (level < DEF_CAPACITY) level++;
      ACT_REMOVE: if (level > 0) level--;
      ACT_CLEAR:  level = 0;
      default: ;
    endcase
  endtask

  task wait_all_replies();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // extremes, many small values for ties, and full-range values
  function automatic logic [DATA_W-1:0] pick_value();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0: return '0;
      1: return '1;
      2, 3, 4: return DATA_W'($urandom_range(0, 15));
      default: return $urandom;
    endcase
  endfunction

  // mostly a live index, sometimes anywhere
  function automatic logic [POS_W-1:0] pick_position();
    if (level > 0 && $urandom_range(0, 9) < 8) return POS_W'($urandom_range(0, level - 1));
    return POS_W'($urandom_range(0, 63));
  endfunction

  task send_mixed_item();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 35) send_item(ACT_INSERT, pick_value(), POS_W'($urandom));
    else if (sel < 60) send_item(ACT_REMOVE, $urandom, POS_W'($urandom));
    else if (sel < 75) send_item(ACT_CHANGE, pick_value(), pick_position());
    else if (sel < 93) send_item(ACT_READ, $urandom, pick_position());
    else if (sel < 96) send_item(ACT_CLEAR, $urandom, POS_W'($urandom));
    else send_item(ACT_UNUSED_LO + ACT_W'($urandom_range(0, 2)), $urandom, POS_W'($urandom));
  endtask

  task run_episode();
    int kind;
    kind = $urandom_range(0, 9);
    case (kind)
      // fill to capacity, overflow, then touch the last slot
      0, 1: begin
        while (level < DEF_CAPACITY) send_item(ACT_INSERT, pick_value(), POS_W'($urandom));
        send_item(ACT_INSERT, pick_value(), POS_W'($urandom));
        send_item(ACT_READ, $urandom, POS_W'(DEF_CAPACITY - 1));
        send_item(ACT_CHANGE, pick_value(), POS_W'(DEF_CAPACITY - 1));
      end
      // drain to empty and one remove past it
      2, 3: begin
        while (level > 0) send_item(ACT_REMOVE, $urandom, POS_W'($urandom));
        send_item(ACT_REMOVE, $urandom, POS_W'($urandom));
      end
      // noise: any action, any field
      9: begin
        repeat (8) send_item(ACT_W'($urandom), $urandom, POS_W'($urandom));
      end
      default: begin
        repeat (20) send_mixed_item();
      end
    endcase
  endtask

  initial begin
    int directed_count;
    int phase;
    int cur_phase;
    bit hold_done;
    cur_phase = 0;
    hold_done = 1'b0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // errors on an empty queue
    send_item(ACT_REMOVE, 32'h0, 6'd0);
    send_item(ACT_READ, 32'h0, 6'd0);
    send_item(ACT_CHANGE, 32'h1234_5678, 6'd63);
    // extremes and equal values
    send_item(ACT_INSERT, 32'h0000_0000, 6'd0);
    send_item(ACT_INSERT, 32'hFFFF_FFFF, 6'd63);
    send_item(ACT_INSERT, 32'h8000_0000, 6'd0);
    send_item(ACT_INSERT, 32'h0000_0005, 6'd0);
    send_item(ACT_INSERT, 32'h0000_0005, 6'd0);
    send_item(ACT_INSERT, 32'h0000_0005, 6'd0);
    send_item(ACT_READ, 32'h0, 6'd0);
    send_item(ACT_READ, 32'h0, 6'd5);
    send_item(ACT_READ, 32'h0, 6'd6);
    send_item(ACT_READ, 32'hFFFF_FFFF, 6'd63);
    // change to an equal value, downward, upward
    send_item(ACT_CHANGE, 32'h0000_0005, 6'd4);
    send_item(ACT_CHANGE, 32'h0000_0000, 6'd2);
    send_item(ACT_CHANGE, 32'hFFFF_FFFE, 6'd3);
    send_item(ACT_REMOVE, 32'h0, 6'd0);
    // unused action codes
    send_item(ACT_UNUSED_LO, 32'hFFFF_FFFF, 6'd63);
    send_item(ACT_UNUSED_LO + 3'd1, 32'h0, 6'd0);
    send_item(ACT_UNUSED_HI, 32'hA5A5_5A5A, 6'd21);
    send_item(ACT_CLEAR, 32'h0, 6'd0);
    send_item(ACT_REMOVE, 32'h0, 6'd0);
    directed_count = items_sent;

    // random part, idle profile stepped by progress
    while (items_sent < directed_count + RANDOM_ITEMS) begin
      phase = (items_sent - directed_count) * 4 / RANDOM_ITEMS;
      if (phase > 3) phase = 3;
      if (phase != cur_phase) begin
        // let the queue go quiet before changing the idle profile
        wait_all_replies();
        cur_phase = phase;
        case (phase)
          1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
          2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
          default: begin send_idle_pct = 37; recv_stall_pct = 37; end
        endcase
      end
      if (!hold_done && items_sent >= directed_count + 200) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      run_episode();
    end

    wait_all_replies();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

/* sim.f */
hdl/bmhpq_pkg.sv
hdl/binary_max_heap_priority_queue.sv
hdl/bmhpq_checker.sv
tb/sv/pq_check_pkg.sv
tb/sv/tb.sv
